// ----- design/lsau_pkg.sv -----
// ----------------------------------------------------------------------------
// lsau_pkg
// shared types and constants of the load/store addressing unit
// ----------------------------------------------------------------------------
package lsau_pkg;

	localparam int ADDR_WIDTH = 16;

	typedef enum logic [2:0] {
		ACT_WRITE = 3'd0,
		ACT_READ  = 3'd1,
		ACT_SETPC = 3'd2,
		ACT_LOAD  = 3'd3,
		ACT_STORE = 3'd4
	} action_t;

	typedef enum logic [3:0] {
		AM_IMPL = 4'd0,
		AM_ACC  = 4'd1,
		AM_IMM  = 4'd2,
		AM_ZP   = 4'd3,
		AM_ZPX  = 4'd4,
		AM_ZPY  = 4'd5,
		AM_REL  = 4'd6,
		AM_ABS  = 4'd7,
		AM_ABSX = 4'd8,
		AM_ABSY = 4'd9,
		AM_IND  = 4'd10,
		AM_INDX = 4'd11,
		AM_INDY = 4'd12
	} amode_t;

	localparam logic [1:0] REG_A = 2'd0;
	localparam logic [1:0] REG_X = 2'd1;
	localparam logic [1:0] REG_Y = 2'd2;

	localparam logic [7:0] NEG_BIT  = 8'h80;
	localparam logic [7:0] ZERO_BIT = 8'h02;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OP1,
		ST_OP2,
		ST_PTR1,
		ST_PTR2,
		ST_DATA,
		ST_WRITE,
		ST_HREAD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  reg_select;
		logic [3:0]  addressing_mode;
		logic [15:0] host_address;
		logic [7:0]  host_data;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] effective_address;
		logic        page_crossed;
		logic [7:0]  accumulator;
		logic [7:0]  index_x;
		logic [7:0]  index_y;
		logic [7:0]  status_flags;
		logic [15:0] program_counter_out;
		logic [3:0]  cycles_spent;
		logic        mode_error;
	} out_word_t;

endpackage

// ----- design/lsau_if.sv -----
// ----------------------------------------------------------------------------
// lsau_if
// valid/ready channel carrying one word of type T
// ----------------------------------------------------------------------------
interface lsau_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- design/cpu_load_store_addressing_unit.sv -----
// ----------------------------------------------------------------------------
// cpu_load_store_addressing_unit
// 6502 style load/store unit: operand fetch, addressing modes, byte memory
// ----------------------------------------------------------------------------
// channel  dir  word         handshake
// in_ch    in   in_word_t    valid/ready
// out_ch   out  out_word_t   valid/ready
//
// at most one memory access per cycle on a single-port synchronous ram with
// registered read data; every memory read has an issue step and a capture
// step, a store write is a single write, and the DONE state registers the
// result word; an absolute indirect (AM_IND) load makes five memory reads
// the result sits in an output register and blocks the input until taken;
// the next word is accepted the cycle after that; reset clears the state,
// acc, x, y, status flags, pc and the wait and output valid flags, not the
// memory or the other registers
module cpu_load_store_addressing_unit
	import lsau_pkg::*;
(
	input logic clk,
	input logic arst_n,
	lsau_if.sink   in_ch,
	lsau_if.source out_ch
);

	localparam int AW = ADDR_WIDTH;

	logic [7:0] mem [2**AW];
	logic [7:0] rdata;
	logic [AW-1:0] maddr;
	logic mrd, mwr;
	logic [7:0] mwdata;

	// synchronous ram
	always_ff @(posedge clk) begin
		if (mwr) mem[maddr] <= mwdata;
		if (mrd) rdata <= mem[maddr];
	end

	state_t state_q, state_d;
	in_word_t req_q;
	logic [7:0] acc_q, x_q, y_q, st_q;
	logic [AW-1:0] pc_q;
	logic [7:0] lo_q, zp_q;
	logic [15:0] ea_q;
	logic cross_q;
	logic [3:0] cyc_q;
	logic wait_q;           // memory read in flight
	out_word_t out_q;
	logic ovalid_q;

	logic store, bad, load_ok;
	logic [7:0] idx, srcv;
	logic [8:0] lsum;
	amode_t md;

	assign md    = amode_t'(req_q.addressing_mode);
	assign store = req_q.action == ACT_STORE;
	assign idx   = (md == AM_ABSX || md == AM_ZPX || md == AM_INDX) ? x_q : y_q;
	assign srcv  = (req_q.reg_select == REG_A) ? acc_q :
		(req_q.reg_select == REG_X) ? x_q : y_q;
	assign lsum  = {1'b0, lo_q} + {1'b0, idx};

	always_comb begin
		bad = 1'b0;
		if (in_ch.payload.reg_select > REG_Y) bad = 1'b1;
		case (in_ch.payload.addressing_mode)
			AM_IMM: bad = bad | (in_ch.payload.action == ACT_STORE);
			AM_ZP, AM_ZPX, AM_ZPY, AM_ABS, AM_ABSX, AM_ABSY,
			AM_IND, AM_INDX, AM_INDY: ;
			default: bad = 1'b1;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;
	assign out_ch.valid = ovalid_q;
	assign out_ch.payload = out_q;
	assign load_ok = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: ;
			ST_HREAD: if (wait_q) state_d = ST_DONE;
			ST_OP1: if (wait_q) begin
				case (md)
					AM_ABS, AM_ABSX, AM_ABSY, AM_IND: state_d = ST_OP2;
					AM_INDX, AM_INDY: state_d = ST_PTR1;
					default: state_d = store ? ST_WRITE : ST_DATA;
				endcase
			end
			ST_OP2: if (wait_q)
				state_d = (md == AM_IND) ? ST_PTR1 : (store ? ST_WRITE : ST_DATA);
			ST_PTR1: if (wait_q) state_d = ST_PTR2;
			ST_PTR2: if (wait_q) state_d = store ? ST_WRITE : ST_DATA;
			ST_DATA: if (wait_q) state_d = ST_DONE;
			ST_WRITE: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
			case (in_ch.payload.action)
				ACT_READ: state_d = ST_HREAD;
				ACT_LOAD, ACT_STORE: begin
					if (bad) state_d = ST_DONE;
					else if (in_ch.payload.addressing_mode == AM_IMM) state_d = ST_DATA;
					else state_d = ST_OP1;
				end
				default: state_d = ST_DONE;
			endcase
		end
	end

	// memory port outputs
	always_comb begin
		mrd = 1'b0;
		mwr = 1'b0;
		maddr = '0;
		mwdata = srcv;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid && in_ch.ready &&
				in_ch.payload.action == ACT_WRITE) begin
				mwr = 1'b1;
				maddr = in_ch.payload.host_address[AW-1:0];
				mwdata = in_ch.payload.host_data;
			end
			ST_HREAD: begin
				mrd = !wait_q;
				maddr = req_q.host_address[AW-1:0];
			end
			ST_OP1, ST_OP2: begin
				mrd = !wait_q;
				maddr = pc_q;
			end
			ST_PTR1: begin
				mrd = !wait_q;
				maddr = (md == AM_IND) ? ea_q[AW-1:0] : AW'(zp_q);
			end
			ST_PTR2: begin
				mrd = !wait_q;
				maddr = (md == AM_IND) ? AW'(ea_q + 16'd1) : AW'(8'(zp_q + 8'd1));
			end
			ST_DATA: begin
				mrd = !wait_q;
				maddr = ea_q[AW-1:0];
			end
			ST_WRITE: begin
				mwr = 1'b1;
				maddr = ea_q[AW-1:0];
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q <= '0;
			x_q <= '0;
			y_q <= '0;
			st_q <= '0;
			pc_q <= '0;
			wait_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ch.valid && out_ch.ready) ovalid_q <= 1'b0;
			wait_q <= mrd;
			if (state_q == ST_IDLE && in_ch.valid && in_ch.ready) begin
				req_q <= in_ch.payload;
				cross_q <= 1'b0;
				cyc_q <= (in_ch.payload.action == ACT_WRITE) ? 4'd1 : 4'd0;
				out_q.read_data <= '0;
				out_q.mode_error <= (in_ch.payload.action == ACT_LOAD ||
					in_ch.payload.action == ACT_STORE) && bad;
				if ((in_ch.payload.action == ACT_LOAD) && !bad &&
					in_ch.payload.addressing_mode == AM_IMM) begin
					ea_q <= 16'(pc_q);
					pc_q <= pc_q + 1'b1;
				end else begin
					ea_q <= '0;
					if (in_ch.payload.action == ACT_SETPC)
						pc_q <= in_ch.payload.host_address[AW-1:0];
				end
			end
			case (state_q)
				ST_HREAD: if (wait_q) begin
					out_q.read_data <= rdata;
					cyc_q <= 4'd1;
				end
				ST_OP1: if (wait_q) begin
					pc_q <= pc_q + 1'b1;
					lo_q <= rdata;
					// indexed zero page and (zp,x) also charge the index add to cyc_q
					cyc_q <= (md inside {AM_ZPX, AM_ZPY, AM_INDX}) ? cyc_q + 4'd2 :
						cyc_q + 4'd1;
					zp_q <= (md == AM_INDX) ? 8'(rdata + x_q) : rdata;
					case (md)
						AM_ZP: ea_q <= {8'd0, rdata};
						AM_ZPX, AM_ZPY: ea_q <= {8'd0, 8'(rdata + idx)};
						default: ;
					endcase
				end
				ST_OP2: if (wait_q) begin
					pc_q <= pc_q + 1'b1;
					case (md)
						AM_ABSX, AM_ABSY: begin
							ea_q <= 16'(({rdata, 8'd0} + {7'd0, lsum}) & ((2**AW) - 1));
							cross_q <= lsum[8];
							cyc_q <= cyc_q + 4'd2 + {3'd0, lsum[8]};
						end
						default: begin
							ea_q <= 16'({rdata, lo_q} & ((2**AW) - 1));
							cyc_q <= cyc_q + 4'd1;
						end
					endcase
				end
				ST_PTR1: if (wait_q) begin
					lo_q <= rdata;
					cyc_q <= cyc_q + 4'd1;
				end
				ST_PTR2: if (wait_q) begin
					if (md == AM_INDY) begin
						ea_q <= 16'(({rdata, 8'd0} + {7'd0, lsum}) & ((2**AW) - 1));
						cross_q <= lsum[8];
						cyc_q <= cyc_q + 4'd2 + {3'd0, lsum[8]};
					end else begin
						ea_q <= 16'({rdata, lo_q} & ((2**AW) - 1));
						cyc_q <= cyc_q + 4'd1;
					end
				end
				ST_DATA: if (wait_q && load_ok) begin
					cyc_q <= cyc_q + 4'd2;
					out_q.read_data <= rdata;
					st_q <= (st_q & ~(ZERO_BIT | NEG_BIT)) |
						((rdata == 8'd0) ? ZERO_BIT : 8'd0) | (rdata & NEG_BIT);
					case (req_q.reg_select)
						REG_A: acc_q <= rdata;
						REG_X: x_q <= rdata;
						default: y_q <= rdata;
					endcase
				end
				ST_WRITE: cyc_q <= cyc_q + 4'd2;
				ST_DONE: begin
					ovalid_q <= 1'b1;
					out_q.effective_address <= ea_q;
					out_q.page_crossed <= cross_q;
					out_q.accumulator <= acc_q;
					out_q.index_x <= x_q;
					out_q.index_y <= y_q;
					out_q.status_flags <= st_q;
					out_q.program_counter_out <= 16'(pc_q);
					out_q.cycles_spent <= cyc_q;
				end
				default: ;
			endcase
		end
	end

endmodule
